FILE: sv/bfha_pkg.sv
// Shared types and codes for the best-fit heap allocator.
// Used by the top level and the testbench; depends on nothing.
`default_nettype none

package bfha_pkg;

    localparam int HDR_W       = 8;
    localparam int LIMIT_W     = 21;
    localparam int CFG_DATA_W  = 21;
    localparam int CFG_INDEX_W = 1;
    localparam int MODE_W      = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SIZE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEAP_LIMIT  = 1'b1;

    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESIZE = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ZERO    = 2'd1,
        STATUS_NOSPACE = 2'd2,
        STATUS_BADADDR = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_RESIZE,
        OP_RESIZE_FREE
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_BEST,
        ST_ALLOC,
        ST_FREE_RDP,
        ST_FREE_RDN,
        ST_FREE_MRG,
        ST_SHIFT,
        ST_INSERT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: sv/bfha_table.sv
// Block table storage: one write port and one read port with registered data.
// Instantiated by the allocator top level; no package dependencies.
`default_nettype none

module bfha_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 42
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: sv/best_fit_heap_allocator_unit.sv
// Allocate scans the table for the best fit and, when a split leaves a free remainder, shifts the
// entries above the block up to insert it; free finds the block and, when a merge removes entries,
// shifts the entries above it down; resize scans first and, when it moves, frees the old block
// after the allocate. A held result waits.
// Throughput: one transaction at a time; the input is not ready while one is in work.
// Reset (aresetn low, synchronous) empties the table and restores header 32 and limit 1 MiB.
`default_nettype none

module best_fit_heap_allocator_unit #(
    parameter int MAX_BLOCKS     = 64,
    parameter int HEAP_ADDR_BITS = 20
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    // mode, request_size, address
    input  wire logic [((3+2*HEAP_ADDR_BITS+7)/8)*8-1:0]  s_tdata,

    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    // status, address_out, moved, copy_bytes, bytes_in_use
    output logic      [((5+3*HEAP_ADDR_BITS+7)/8)*8-1:0]  m_tdata,

    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [bfha_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  wire logic [bfha_pkg::CFG_DATA_W-1:0]          cfg_data
);

    localparam int A     = HEAP_ADDR_BITS;
    localparam int S     = HEAP_ADDR_BITS + 1;
    localparam int IW    = $clog2(MAX_BLOCKS);
    localparam int CNW   = $clog2(MAX_BLOCKS + 1);
    localparam int EW    = 1 + S + A;
    localparam int CW    = (HEAP_ADDR_BITS + 3 > 22) ? HEAP_ADDR_BITS + 3 : 22;
    localparam int OUT_W = ((5 + 3 * HEAP_ADDR_BITS + 7) / 8) * 8;

    bfha_pkg::state_t  state_reg, state_next;
    bfha_pkg::op_t     op_reg, op_next;
    bfha_pkg::status_t res_status_reg, res_status_next;

    logic [bfha_pkg::HDR_W-1:0]   header_reg;
    logic [bfha_pkg::LIMIT_W-1:0] limit_reg;

    logic [CNW-1:0] count_reg, count_next;
    logic [S-1:0]   heap_end_reg, heap_end_next;
    logic [S-1:0]   in_use_reg, in_use_next;

    logic [S-1:0]   req_reg, req_next;
    logic [A-1:0]   addr_reg, addr_next;
    logic [A-1:0]   res_addr_reg, res_addr_next;
    logic           res_moved_reg, res_moved_next;
    logic [S-1:0]   res_copy_reg, res_copy_next;
    logic [S-1:0]   old_reg, old_next;

    logic [CNW-1:0] ptr_reg, ptr_next;
    logic           pend_vld_reg, pend_vld_next;
    logic [IW-1:0]  pend_idx_reg, pend_idx_next;
    logic           found_reg, found_next;
    logic [IW-1:0]  cur_idx_reg, cur_idx_next;
    logic [EW-1:0]  cur_word_reg, cur_word_next;
    logic [EW-1:0]  prev_word_reg, prev_word_next;
    logic [EW-1:0]  ins_word_reg, ins_word_next;
    logic [IW-1:0]  ins_idx_reg, ins_idx_next;

    logic [IW-1:0]  src_reg, src_next;
    logic [CNW-1:0] rem_reg, rem_next;
    logic [1:0]     dist_reg, dist_next;
    logic           shift_up_reg, shift_up_next;

    logic           m_tvalid_reg, m_tvalid_next;
    logic [1:0]     out_status_reg;
    logic [A-1:0]   out_addr_reg;
    logic           out_moved_reg;
    logic [S-1:0]   out_copy_reg;
    logic [S-1:0]   out_bytes_reg;
    logic           out_load;

    logic           wr_en;
    logic [IW-1:0]  wr_addr;
    logic [EW-1:0]  wr_data;
    logic [IW-1:0]  rd_addr;
    logic [EW-1:0]  rd_data;

    logic [bfha_pkg::MODE_W-1:0] in_mode;
    logic [S-1:0]   in_req;
    logic [A-1:0]   in_addr;

    logic [bfha_pkg::HDR_W-1:0] hdr;
    logic           e_free;
    logic [S-1:0]   e_size;
    logic [A-1:0]   e_start;
    logic [S-1:0]   cur_size;
    logic [A-1:0]   cur_start;
    logic [S-1:0]   prev_size;
    logic [A-1:0]   prev_start;
    logic           scan_issue, scan_done, shift_issue;
    logic           has_prev, has_next, prev_free, next_free;
    logic           split_ok, full, over_limit, alloc_end;
    logic [CW-1:0]  need_end, lim_eff;
    logic [CNW-1:0] pos_next_c;
    logic [S-1:0]   sum_prev, sum_all, sum_next;

    assign in_mode = s_tdata[1:0];
    assign in_req  = s_tdata[S+1:2];
    assign in_addr = s_tdata[S+A+1:S+2];

    assign s_tready  = (state_reg == bfha_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = OUT_W'({out_bytes_reg, out_copy_reg, out_moved_reg,
                               out_addr_reg, out_status_reg});

    bfha_table #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IW),
        .DW    (EW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign hdr        = (header_reg == '0) ? bfha_pkg::HDR_W'(1) : header_reg;
    assign e_free     = rd_data[EW-1];
    assign e_size     = rd_data[EW-2:A];
    assign e_start    = rd_data[A-1:0];
    assign cur_size   = cur_word_reg[EW-2:A];
    assign cur_start  = cur_word_reg[A-1:0];
    assign prev_size  = prev_word_reg[EW-2:A];
    assign prev_start = prev_word_reg[A-1:0];

    assign scan_issue  = ptr_reg < count_reg;
    assign scan_done   = !scan_issue && !pend_vld_reg;
    assign shift_issue = rem_reg != '0;

    assign has_prev   = cur_idx_reg != '0;
    assign pos_next_c = CNW'(cur_idx_reg) + CNW'(1);
    assign has_next   = pos_next_c < count_reg;
    assign prev_free  = has_prev && prev_word_reg[EW-1];
    assign next_free  = has_next && e_free;
    assign sum_prev   = prev_size + S'(hdr) + cur_size;
    assign sum_all    = sum_prev + S'(hdr) + e_size;
    assign sum_next   = cur_size + S'(hdr) + e_size;

    assign split_ok   = ({1'b0, cur_size} > ((S+1)'(req_reg) + (S+1)'(hdr)))
                        && (count_reg < CNW'(MAX_BLOCKS));
    assign full       = count_reg >= CNW'(MAX_BLOCKS);
    assign need_end   = CW'(heap_end_reg) + CW'(hdr) + CW'(req_reg);
    assign lim_eff    = (CW'(limit_reg) > (CW'(1) << A)) ? (CW'(1) << A) : CW'(limit_reg);
    assign over_limit = need_end > lim_eff;
    assign out_load   = (state_reg == bfha_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        res_status_next = res_status_reg;
        count_next      = count_reg;
        heap_end_next   = heap_end_reg;
        in_use_next     = in_use_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        res_addr_next   = res_addr_reg;
        res_moved_next  = res_moved_reg;
        res_copy_next   = res_copy_reg;
        old_next        = old_reg;
        ptr_next        = ptr_reg;
        pend_vld_next   = 1'b0;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        cur_idx_next    = cur_idx_reg;
        cur_word_next   = cur_word_reg;
        prev_word_next  = prev_word_reg;
        ins_word_next   = ins_word_reg;
        ins_idx_next    = ins_idx_reg;
        src_next        = src_reg;
        rem_next        = rem_reg;
        dist_next       = dist_reg;
        shift_up_next   = shift_up_reg;
        m_tvalid_next   = m_tvalid_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_addr         = ptr_reg[IW-1:0];
        alloc_end       = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            bfha_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    req_next        = in_req;
                    addr_next       = in_addr;
                    res_status_next = bfha_pkg::STATUS_OK;
                    res_addr_next   = '0;
                    res_moved_next  = 1'b0;
                    res_copy_next   = '0;
                    ptr_next        = '0;
                    found_next      = 1'b0;
                    if (in_mode == bfha_pkg::MODE_FREE) begin
                        op_next    = bfha_pkg::OP_FREE;
                        state_next = (in_addr == '0) ? bfha_pkg::ST_DONE : bfha_pkg::ST_FIND;
                    end else if (in_mode == bfha_pkg::MODE_RESIZE && in_addr != '0) begin
                        op_next    = bfha_pkg::OP_RESIZE;
                        state_next = bfha_pkg::ST_FIND;
                    end else begin
                        op_next = bfha_pkg::OP_ALLOC;
                        if (in_req == '0) begin
                            res_status_next = bfha_pkg::STATUS_ZERO;
                            state_next      = bfha_pkg::ST_DONE;
                        end else begin
                            state_next = bfha_pkg::ST_BEST;
                        end
                    end
                end
            end

            bfha_pkg::ST_FIND: begin
                if (scan_issue) begin
                    ptr_next      = ptr_reg + CNW'(1);
                    pend_vld_next = 1'b1;
                    pend_idx_next = ptr_reg[IW-1:0];
                end
                if (pend_vld_reg && !found_reg && !e_free
                        && (A'(e_start + A'(hdr)) == addr_reg)) begin
                    found_next    = 1'b1;
                    cur_idx_next  = pend_idx_reg;
                    cur_word_next = rd_data;
                end
                if (scan_done) begin
                    if (op_reg == bfha_pkg::OP_RESIZE_FREE) begin
                        state_next = found_reg ? bfha_pkg::ST_FREE_RDP : bfha_pkg::ST_DONE;
                    end else if (!found_reg) begin
                        res_status_next = bfha_pkg::STATUS_BADADDR;
                        state_next      = bfha_pkg::ST_DONE;
                    end else if (op_reg == bfha_pkg::OP_FREE) begin
                        state_next = bfha_pkg::ST_FREE_RDP;
                    end else if (cur_size >= req_reg) begin
                        res_addr_next = addr_reg;
                        state_next    = bfha_pkg::ST_DONE;
                    end else begin
                        old_next   = cur_size;
                        found_next = 1'b0;
                        ptr_next   = '0;
                        state_next = bfha_pkg::ST_BEST;
                    end
                end
            end

            bfha_pkg::ST_BEST: begin
                if (scan_issue) begin
                    ptr_next      = ptr_reg + CNW'(1);
                    pend_vld_next = 1'b1;
                    pend_idx_next = ptr_reg[IW-1:0];
                end
                if (pend_vld_reg && e_free && e_size >= req_reg
                        && (!found_reg || e_size < cur_size)) begin
                    found_next    = 1'b1;
                    cur_idx_next  = pend_idx_reg;
                    cur_word_next = rd_data;
                end
                if (scan_done) begin
                    state_next = bfha_pkg::ST_ALLOC;
                end
            end

            bfha_pkg::ST_ALLOC: begin
                if (found_reg) begin
                    res_addr_next = A'(cur_start + A'(hdr));
                    wr_en         = 1'b1;
                    wr_addr       = cur_idx_reg;
                    if (split_ok) begin
                        wr_data       = {1'b0, req_reg, cur_start};
                        in_use_next   = in_use_reg + req_reg;
                        ins_word_next = {1'b1, S'(cur_size - req_reg - S'(hdr)),
                                         A'(cur_start + A'(hdr) + A'(req_reg))};
                        ins_idx_next  = cur_idx_reg + IW'(1);
                        shift_up_next = 1'b1;
                        dist_next     = 2'd1;
                        src_next      = IW'(count_reg - CNW'(1));
                        rem_next      = count_reg - pos_next_c;
                        state_next    = bfha_pkg::ST_SHIFT;
                    end else begin
                        wr_data     = {1'b0, cur_size, cur_start};
                        in_use_next = in_use_reg + cur_size;
                        alloc_end   = 1'b1;
                    end
                end else if (full || over_limit) begin
                    res_status_next = bfha_pkg::STATUS_NOSPACE;
                    state_next      = bfha_pkg::ST_DONE;
                end else begin
                    wr_en         = 1'b1;
                    wr_addr       = count_reg[IW-1:0];
                    wr_data       = {1'b0, req_reg, heap_end_reg[A-1:0]};
                    count_next    = count_reg + CNW'(1);
                    res_addr_next = A'(heap_end_reg[A-1:0] + A'(hdr));
                    heap_end_next = S'(need_end);
                    in_use_next   = in_use_reg + req_reg;
                    alloc_end     = 1'b1;
                end
            end

            bfha_pkg::ST_INSERT: begin
                wr_en      = 1'b1;
                wr_addr    = ins_idx_reg;
                wr_data    = ins_word_reg;
                count_next = count_reg + CNW'(1);
                alloc_end  = 1'b1;
            end

            bfha_pkg::ST_FREE_RDP: begin
                rd_addr    = cur_idx_reg - IW'(1);
                state_next = bfha_pkg::ST_FREE_RDN;
            end

            bfha_pkg::ST_FREE_RDN: begin
                rd_addr        = cur_idx_reg + IW'(1);
                prev_word_next = rd_data;
                state_next     = bfha_pkg::ST_FREE_MRG;
            end

            bfha_pkg::ST_FREE_MRG: begin
                in_use_next   = in_use_reg - cur_size;
                wr_en         = 1'b1;
                shift_up_next = 1'b0;
                state_next    = bfha_pkg::ST_SHIFT;
                if (prev_free && next_free) begin
                    wr_addr    = cur_idx_reg - IW'(1);
                    wr_data    = {1'b1, sum_all, prev_start};
                    dist_next  = 2'd2;
                    src_next   = cur_idx_reg + IW'(2);
                    rem_next   = count_reg - CNW'(cur_idx_reg) - CNW'(2);
                    count_next = count_reg - CNW'(2);
                end else if (prev_free) begin
                    wr_addr    = cur_idx_reg - IW'(1);
                    wr_data    = {1'b1, sum_prev, prev_start};
                    dist_next  = 2'd1;
                    src_next   = cur_idx_reg + IW'(1);
                    rem_next   = count_reg - pos_next_c;
                    count_next = count_reg - CNW'(1);
                end else if (next_free) begin
                    wr_addr    = cur_idx_reg;
                    wr_data    = {1'b1, sum_next, cur_start};
                    dist_next  = 2'd1;
                    src_next   = cur_idx_reg + IW'(2);
                    rem_next   = count_reg - pos_next_c - CNW'(1);
                    count_next = count_reg - CNW'(1);
                end else begin
                    wr_addr    = cur_idx_reg;
                    wr_data    = {1'b1, cur_size, cur_start};
                    state_next = bfha_pkg::ST_DONE;
                end
            end

            bfha_pkg::ST_SHIFT: begin
                rd_addr = src_reg;
                if (shift_issue) begin
                    src_next      = shift_up_reg ? src_reg - IW'(1) : src_reg + IW'(1);
                    rem_next      = rem_reg - CNW'(1);
                    pend_vld_next = 1'b1;
                    pend_idx_next = src_reg;
                end
                if (pend_vld_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = shift_up_reg ? pend_idx_reg + IW'(1)
                                           : pend_idx_reg - IW'(dist_reg);
                    wr_data = rd_data;
                end
                if (!shift_issue && !pend_vld_reg) begin
                    state_next = shift_up_reg ? bfha_pkg::ST_INSERT : bfha_pkg::ST_DONE;
                end
            end

            bfha_pkg::ST_DONE: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    state_next    = bfha_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = bfha_pkg::ST_IDLE;
            end
        endcase

        if (alloc_end) begin
            if (op_reg == bfha_pkg::OP_RESIZE) begin
                res_moved_next = 1'b1;
                res_copy_next  = old_reg;
                op_next        = bfha_pkg::OP_RESIZE_FREE;
                found_next     = 1'b0;
                ptr_next       = '0;
                state_next     = bfha_pkg::ST_FIND;
            end else begin
                state_next = bfha_pkg::ST_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bfha_pkg::ST_IDLE;
            count_reg    <= '0;
            heap_end_reg <= '0;
            in_use_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            header_reg   <= bfha_pkg::HDR_W'(32);
            limit_reg    <= bfha_pkg::LIMIT_W'(1048576);
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            heap_end_reg <= heap_end_next;
            in_use_reg   <= in_use_next;
            m_tvalid_reg <= m_tvalid_next;
            pend_vld_reg <= pend_vld_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == bfha_pkg::REG_HEADER_SIZE) begin
                    header_reg <= cfg_data[bfha_pkg::HDR_W-1:0];
                end else begin
                    limit_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        res_status_reg <= res_status_next;
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        res_addr_reg   <= res_addr_next;
        res_moved_reg  <= res_moved_next;
        res_copy_reg   <= res_copy_next;
        old_reg        <= old_next;
        ptr_reg        <= ptr_next;
        pend_idx_reg   <= pend_idx_next;
        found_reg      <= found_next;
        cur_idx_reg    <= cur_idx_next;
        cur_word_reg   <= cur_word_next;
        prev_word_reg  <= prev_word_next;
        ins_word_reg   <= ins_word_next;
        ins_idx_reg    <= ins_idx_next;
        src_reg        <= src_next;
        rem_reg        <= rem_next;
        dist_reg       <= dist_next;
        shift_up_reg   <= shift_up_next;
        if (out_load) begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_moved_reg  <= res_moved_reg;
            out_copy_reg   <= res_copy_reg;
            out_bytes_reg  <= in_use_reg;
        end
    end

endmodule

`default_nettype wire

FILE: sv/bfha_checker.sv
// Port-level checks for the best-fit heap allocator, bound to its top level.
// Depends on the top level's ports only.
`default_nettype none

module bfha_checker #(
    parameter int HEAP_ADDR_BITS = 20
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((5+3*HEAP_ADDR_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int A = HEAP_ADDR_BITS;

    logic [1:0]   res_status;
    logic [A-1:0] res_addr;
    logic         res_moved;
    logic [A:0]   res_copy;

    assign res_status = m_tdata[1:0];
    assign res_addr   = m_tdata[A+1:2];
    assign res_moved  = m_tdata[A+2];
    assign res_copy   = m_tdata[2*A+3:A+3];

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transaction");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_status != 2'd0 |-> res_addr == '0 && !res_moved)
        else $error("failed request reports an address or a move");

    a_copy_only_moved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res_moved |-> res_copy == '0)
        else $error("copy size without a move");

endmodule

bind best_fit_heap_allocator_unit bfha_checker #(
    .HEAP_ADDR_BITS (HEAP_ADDR_BITS)
) u_bfha_checker (.*);

`default_nettype wire

FILE: tb/tb_best_fit_heap_allocator_unit.sv
// Self-checking testbench for best_fit_heap_allocator_unit: directed and random
// allocate, free and resize traffic under several header and heap limit settings.
// Depends on bfha_pkg and the allocator RTL only.
`timescale 1ns / 1ps

class alloc_scoreboard;
    typedef struct {
        bfha_pkg::status_t status;
        logic [19:0]       addr_out;
        logic              moved;
        logic [20:0]       copy_bytes;
        logic [20:0]       in_use;
    } alloc_result_t;

    localparam longint M20 = 64'hFFFFF;
    localparam longint M21 = 64'h1FFFFF;
    localparam int     BLOCKS = 64;

    longint        blk_start[BLOCKS];
    longint        blk_size[BLOCKS];
    bit            blk_free[BLOCKS];
    int            blk_count;
    longint        heap_end;
    longint        in_use_total;
    longint        header_size;
    longint        heap_limit;
    alloc_result_t pending_results[$];
    int            errors;
    int            checked;
    int            moves;
    int            refusals;

    function new();
        blk_count = 0;
        heap_end = 0;
        in_use_total = 0;
        header_size = 32;
        heap_limit = 1048576;
        errors = 0;
        checked = 0;
        moves = 0;
        refusals = 0;
    endfunction

    function void set_register(logic [bfha_pkg::CFG_INDEX_W-1:0] idx, logic [20:0] val);
        if (idx == bfha_pkg::REG_HEADER_SIZE)
            header_size = longint'(val[7:0]);
        else
            heap_limit = longint'(val);
    endfunction

    function longint hdr();
        return (header_size == 0) ? 1 : header_size;
    endfunction

    function longint limit_bytes();
        return (heap_limit > 1048576) ? 1048576 : heap_limit;
    endfunction

    function void insert_block(int pos, longint start, longint size, bit fr);
        for (int k = blk_count; k > pos; k--) begin
            blk_start[k] = blk_start[k-1];
            blk_size[k] = blk_size[k-1];
            blk_free[k] = blk_free[k-1];
        end
        blk_start[pos] = start & M20;
        blk_size[pos] = size & M21;
        blk_free[pos] = fr;
        blk_count++;
    endfunction

    function void remove_block(int pos);
        for (int k = pos; k + 1 < blk_count; k++) begin
            blk_start[k] = blk_start[k+1];
            blk_size[k] = blk_size[k+1];
            blk_free[k] = blk_free[k+1];
        end
        blk_count--;
    endfunction

    function int find_live(longint a);
        for (int i = 0; i < blk_count; i++)
            if (!blk_free[i] && ((blk_start[i] + hdr()) & M20) == a)
                return i;
        return -1;
    endfunction

    // Returns a random live payload offset, or zero when nothing is allocated.
    function logic [19:0] pick_live();
        int live[$];
        for (int i = 0; i < blk_count; i++)
            if (!blk_free[i])
                live.push_back(i);
        if (live.size() == 0)
            return '0;
        return 20'((blk_start[live[$urandom_range(0, live.size() - 1)]] + hdr()) & M20);
    endfunction

    function bfha_pkg::status_t grant(longint req, output logic [19:0] a);
        longint h;
        int     best;
        h = hdr();
        best = -1;
        a = '0;
        if (req == 0)
            return bfha_pkg::STATUS_ZERO;
        for (int i = 0; i < blk_count; i++)
            if (blk_free[i] && blk_size[i] >= req && (best < 0 || blk_size[i] < blk_size[best]))
                best = i;
        if (best >= 0) begin
            blk_free[best] = 1'b0;
            if (blk_size[best] > req + h && blk_count < BLOCKS) begin
                insert_block(best + 1, blk_start[best] + h + req, blk_size[best] - req - h, 1'b1);
                blk_size[best] = req;
            end
            in_use_total = (in_use_total + blk_size[best]) & M21;
            a = 20'((blk_start[best] + h) & M20);
            return bfha_pkg::STATUS_OK;
        end
        if (blk_count >= BLOCKS || heap_end + h + req > limit_bytes())
            return bfha_pkg::STATUS_NOSPACE;
        insert_block(blk_count, heap_end, req, 1'b0);
        a = 20'((heap_end + h) & M20);
        heap_end = (heap_end + h + req) & M21;
        in_use_total = (in_use_total + req) & M21;
        return bfha_pkg::STATUS_OK;
    endfunction

    function void release_block(int i);
        longint h;
        h = hdr();
        in_use_total = (in_use_total - blk_size[i]) & M21;
        blk_free[i] = 1'b1;
        if (i > 0 && blk_free[i-1]) begin
            blk_size[i-1] = (blk_size[i-1] + h + blk_size[i]) & M21;
            remove_block(i);
            i--;
        end
        if (i + 1 < blk_count && blk_free[i+1]) begin
            blk_size[i] = (blk_size[i] + h + blk_size[i+1]) & M21;
            remove_block(i + 1);
        end
    endfunction

    function void note_request(logic [1:0] mode, logic [20:0] req, logic [19:0] addr);
        alloc_result_t r;
        int            idx;
        longint        old;
        r.status = bfha_pkg::STATUS_OK;
        r.addr_out = '0;
        r.moved = 1'b0;
        r.copy_bytes = '0;
        if (mode == bfha_pkg::MODE_FREE) begin
            if (addr != 0) begin
                idx = find_live(longint'(addr));
                if (idx < 0)
                    r.status = bfha_pkg::STATUS_BADADDR;
                else
                    release_block(idx);
            end
        end else if (mode == bfha_pkg::MODE_RESIZE && addr != 0) begin
            idx = find_live(longint'(addr));
            if (idx < 0) begin
                r.status = bfha_pkg::STATUS_BADADDR;
            end else if (blk_size[idx] >= req) begin
                r.addr_out = addr;
            end else begin
                old = blk_size[idx];
                r.status = grant(longint'(req), r.addr_out);
                if (r.status == bfha_pkg::STATUS_OK) begin
                    idx = find_live(longint'(addr));
                    if (idx >= 0)
                        release_block(idx);
                    r.moved = 1'b1;
                    r.copy_bytes = old[20:0];
                    moves++;
                end
            end
        end else begin
            r.status = grant(longint'(req), r.addr_out);
        end
        if (r.status != bfha_pkg::STATUS_OK)
            refusals++;
        r.in_use = in_use_total[20:0];
        pending_results.push_back(r);
    endfunction

    function void check_response(logic [71:0] d);
        alloc_result_t e;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, d);
            errors++;
            return;
        end
        e = pending_results.pop_front();
        checked++;
        if (d[1:0] !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, d[1:0]);
            errors++;
        end
        if (d[21:2] !== e.addr_out) begin
            $display("%0t: address_out expected %h actual %h", $time, e.addr_out, d[21:2]);
            errors++;
        end
        if (d[22] !== e.moved) begin
            $display("%0t: moved expected %0d actual %0d", $time, e.moved, d[22]);
            errors++;
        end
        if (d[43:23] !== e.copy_bytes) begin
            $display("%0t: copy_bytes expected %0d actual %0d", $time, e.copy_bytes, d[43:23]);
            errors++;
        end
        if (d[64:44] !== e.in_use) begin
            $display("%0t: bytes_in_use expected %0d actual %0d", $time, e.in_use, d[64:44]);
            errors++;
        end
    endfunction
endclass

module tb_best_fit_heap_allocator_unit;

    localparam logic [bfha_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [bfha_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bfha_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    alloc_scoreboard sb = new();
    bit              steady = 1'b0;

    best_fit_heap_allocator_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic send_request(logic [1:0] mode, logic [20:0] req, logic [19:0] addr);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, addr, req, mode};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(mode, req, addr);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    task automatic write_register(logic [bfha_pkg::CFG_INDEX_W-1:0] idx, logic [20:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_register(idx, val);
        @(posedge aclk);
    endtask

    task automatic random_traffic(int n, int max_size);
        int          r;
        logic [20:0] sz;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            steady = ($urandom_range(0, 3) == 0);
            sz = ($urandom_range(0, 19) == 0) ? 21'($urandom_range(0, 1048576))
                                               : 21'($urandom_range(1, max_size));
            if (r < 45)
                send_request(bfha_pkg::MODE_ALLOC, sz, 20'($urandom));
            else if (r < 72)
                send_request(bfha_pkg::MODE_FREE,
                             $urandom_range(0, 4) == 0 ? 21'($urandom) : '0,
                             $urandom_range(0, 9) == 0 ? 20'($urandom) : sb.pick_live());
            else if (r < 94)
                send_request(bfha_pkg::MODE_RESIZE, sz,
                             $urandom_range(0, 9) == 0 ? 20'($urandom) : sb.pick_live());
            else
                send_request(MODE_SPARE, sz, 20'($urandom));
        end
        steady = 1'b0;
    endtask

    initial begin
        int drops;
        forever begin
            drops = $urandom_range(0, 5);
            if (drops > 0) begin
                m_tready <= 1'b0;
                repeat (drops) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_response(m_tdata);
        end
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [19:0] a;
        logic [19:0] b;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(bfha_pkg::MODE_ALLOC, 21'd0, '0);
        send_request(bfha_pkg::MODE_ALLOC, 21'd100, '0);
        send_request(bfha_pkg::MODE_ALLOC, 21'd1, '0);
        send_request(bfha_pkg::MODE_ALLOC, 21'd200, '0);
        send_request(bfha_pkg::MODE_ALLOC, 21'd60, '0);
        send_request(bfha_pkg::MODE_FREE, '0, '0);
        send_request(bfha_pkg::MODE_FREE, '0, 20'hFFFFF);
        send_request(bfha_pkg::MODE_RESIZE, 21'd5, 20'd5);
        a = sb.pick_live();
        send_request(bfha_pkg::MODE_FREE, 21'h1FFFFF, a);
        send_request(bfha_pkg::MODE_RESIZE, 21'd50, '0);
        a = sb.pick_live();
        send_request(bfha_pkg::MODE_RESIZE, '0, a);
        send_request(bfha_pkg::MODE_RESIZE, 21'd1, a);
        send_request(bfha_pkg::MODE_RESIZE, 21'd300, a);
        b = sb.pick_live();
        send_request(bfha_pkg::MODE_RESIZE, 21'd1048576, b);
        send_request(MODE_SPARE, 21'd10, 20'hFFFFF);
        send_request(bfha_pkg::MODE_ALLOC, 21'd1048576, '0);
        send_request(bfha_pkg::MODE_ALLOC, 21'h1FFFFF, '0);
        for (int i = 0; i < 6; i++)
            send_request(bfha_pkg::MODE_FREE, '0, sb.pick_live());
        drain();

        // A full pause on the request side before the next batch.
        random_traffic(80, 256);
        drain();

        write_register(bfha_pkg::REG_HEADER_SIZE, 21'd0);
        write_register(bfha_pkg::REG_HEAP_LIMIT, 21'h1FFFFF);
        random_traffic(80, 128);
        drain();

        // Tiny blocks and a short heap fill the block table.
        write_register(bfha_pkg::REG_HEADER_SIZE, 21'd1);
        write_register(bfha_pkg::REG_HEAP_LIMIT, 21'd300000);
        random_traffic(110, 4);
        drain();

        write_register(bfha_pkg::REG_HEADER_SIZE, 21'd255);
        write_register(bfha_pkg::REG_HEAP_LIMIT, 21'd0);
        random_traffic(70, 400);
        drain();

        write_register(bfha_pkg::REG_HEADER_SIZE, 21'd32);
        write_register(bfha_pkg::REG_HEAP_LIMIT, 21'd1048576);
        random_traffic(90, 1024);
        drain();

        $display("Checked %0d results: %0d relocations, %0d refused requests,",
                 sb.checked, sb.moves, sb.refusals);
        $display("over five header and heap limit settings including the extremes.");
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: filelist.f
sv/bfha_pkg.sv
sv/bfha_table.sv
sv/best_fit_heap_allocator_unit.sv
sv/bfha_checker.sv
tb/tb_best_fit_heap_allocator_unit.sv
